// File: hw/rtl/fhta_pkg.sv
package fhta_pkg;

  localparam int NUM_PROCS  = 16;
  localparam int CPU_W      = $clog2(NUM_PROCS);
  localparam int CNT_W      = CPU_W + 1;
  localparam int FRAC_BITS  = 16;
  localparam int CAP_W      = FRAC_BITS + 1;
  localparam int DATA_W     = 32;
  localparam int DVD_W      = DATA_W + FRAC_BITS;
  localparam int DIV_STEPS  = DVD_W;
  localparam int STEP_W     = $clog2(DIV_STEPS);

  localparam int MODE_W     = 2;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = CNT_W;

  localparam logic [MODE_W-1:0] MODE_BEST   = 2'd0;
  localparam logic [MODE_W-1:0] MODE_WORST  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_FIRST  = 2'd2;
  localparam logic [MODE_W-1:0] MODE_SPARE  = 2'd3;

  localparam logic [CFG_IDX_W-1:0] CFG_FIT_MODE    = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_CPUS_IN_USE = 1'b1;

  localparam logic [CAP_W-1:0] CAP_ONE   = CAP_W'(1) << FRAC_BITS;
  localparam logic [CNT_W-1:0] CPUS_RST  = CNT_W'(NUM_PROCS);

  typedef struct packed {
    logic load;
    logic div_step;
    logic scan_step;
    logic commit;
  } cmd_t;

  typedef struct packed {
    logic scan_end;
    logic out_free;
  } sts_t;

endpackage

// File: hw/rtl/fhta_in_if.sv
interface fhta_in_if;
  logic                         valid;
  logic                         ready;
  logic [fhta_pkg::DATA_W-1:0]  exec_time;
  logic [fhta_pkg::DATA_W-1:0]  period;

  modport source (output valid, exec_time, period, input ready);
  modport sink   (input valid, exec_time, period, output ready);
endinterface

// File: hw/rtl/fhta_out_if.sv
interface fhta_out_if;
  logic                         valid;
  logic                         ready;
  logic                         placed;
  logic [fhta_pkg::CPU_W-1:0]   proc_id;
  logic [fhta_pkg::CAP_W-1:0]   capacity_left;

  modport source (output valid, placed, proc_id, capacity_left, input ready);
  modport sink   (input valid, placed, proc_id, capacity_left, output ready);
endinterface

// File: hw/rtl/fhta_ctrl.sv
module fhta_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  fhta_pkg::sts_t      sts,
  output fhta_pkg::cmd_t      cmd
);

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_DIV    = 2'd1;
  localparam logic [1:0] S_SCAN   = 2'd2;
  localparam logic [1:0] S_COMMIT = 2'd3;

  logic [1:0]                    state_r, state_nxt;
  logic [fhta_pkg::STEP_W-1:0]   step_r, step_nxt;

  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          step_nxt  = '0;
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        step_nxt     = step_r + 1'b1;
        if (step_r == fhta_pkg::STEP_W'(fhta_pkg::DIV_STEPS - 1)) begin
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        if (sts.scan_end) begin
          state_nxt = S_COMMIT;
        end else begin
          cmd.scan_step = 1'b1;
        end
      end
      S_COMMIT: begin
        if (sts.out_free) begin
          cmd.commit = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      step_r  <= '0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
    end
  end

endmodule

// File: hw/rtl/fhta_dp.sv
module fhta_dp (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [fhta_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [fhta_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  logic [fhta_pkg::DATA_W-1:0]       exec_time,
  input  logic [fhta_pkg::DATA_W-1:0]       period,
  input  logic                              out_ready,
  output logic                              out_valid,
  output logic                              out_placed,
  output logic [fhta_pkg::CPU_W-1:0]        out_proc_id,
  output logic [fhta_pkg::CAP_W-1:0]        out_capacity_left,
  input  fhta_pkg::cmd_t                    cmd,
  output fhta_pkg::sts_t                    sts
);

  logic [fhta_pkg::MODE_W-1:0]   mode_r;
  logic [fhta_pkg::CNT_W-1:0]    cpus_r;

  logic [fhta_pkg::DATA_W-1:0]   per_r;
  logic [fhta_pkg::DATA_W-1:0]   rem_r;
  logic [fhta_pkg::DVD_W-1:0]    dvd_r;
  logic [fhta_pkg::DATA_W:0]     rem_sh;
  logic                          rem_ge;

  logic [fhta_pkg::CAP_W-1:0]    cap_r [fhta_pkg::NUM_PROCS];
  logic [fhta_pkg::CPU_W-1:0]    idx_r;
  logic [fhta_pkg::CPU_W-1:0]    pick_r;
  logic [fhta_pkg::CAP_W-1:0]    best_r;
  logic                          found_r;
  logic                          over_r;

  logic                          out_valid_r;
  logic                          placed_r;
  logic [fhta_pkg::CPU_W-1:0]    cpu_r;
  logic [fhta_pkg::CAP_W-1:0]    left_r;

  logic [fhta_pkg::CAP_W-1:0]    util;
  logic                          util_big;
  logic [fhta_pkg::CNT_W-1:0]    n_eff;
  logic [fhta_pkg::CAP_W-1:0]    cap_cur;
  logic                          fits;
  logic                          first_fit;
  logic                          take;
  logic                          last;
  logic [fhta_pkg::CAP_W-1:0]    new_cap;

  assign rem_sh = {rem_r, dvd_r[fhta_pkg::DVD_W-1]};
  assign rem_ge = rem_sh >= {1'b0, per_r};

  assign util     = dvd_r[fhta_pkg::CAP_W-1:0];
  assign util_big = |dvd_r[fhta_pkg::DVD_W-1:fhta_pkg::CAP_W];
  assign n_eff    = (cpus_r > fhta_pkg::CPUS_RST) ? fhta_pkg::CPUS_RST : cpus_r;
  assign cap_cur  = cap_r[idx_r];
  assign fits     = !util_big && (cap_cur >= util);
  assign first_fit = (mode_r == fhta_pkg::MODE_FIRST) || (mode_r == fhta_pkg::MODE_SPARE);
  assign last     = ({1'b0, idx_r} + fhta_pkg::CNT_W'(1)) == n_eff;
  assign new_cap  = best_r - util;

  always_comb begin
    take = 1'b0;
    if (fits) begin
      priority if (!found_r) begin
        take = 1'b1;
      end else if (mode_r == fhta_pkg::MODE_BEST) begin
        take = cap_cur < best_r;
      end else if (mode_r == fhta_pkg::MODE_WORST) begin
        take = cap_cur > best_r;
      end else begin
        take = 1'b0;
      end
    end
  end

  assign sts.scan_end = (n_eff == '0) || over_r || (first_fit && found_r);
  assign sts.out_free = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= fhta_pkg::MODE_BEST;
      cpus_r <= fhta_pkg::CPUS_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        fhta_pkg::CFG_FIT_MODE:    mode_r <= cfg_data[fhta_pkg::MODE_W-1:0];
        fhta_pkg::CFG_CPUS_IN_USE: cpus_r <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      per_r <= period;
      rem_r <= '0;
      dvd_r <= {exec_time, fhta_pkg::FRAC_BITS'(0)};
    end else if (cmd.div_step) begin
      rem_r <= rem_ge ? fhta_pkg::DATA_W'(rem_sh - {1'b0, per_r})
                      : rem_sh[fhta_pkg::DATA_W-1:0];
      dvd_r <= {dvd_r[fhta_pkg::DVD_W-2:0], rem_ge};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      found_r <= 1'b0;
      over_r  <= 1'b0;
      idx_r   <= '0;
    end else if (cmd.load) begin
      found_r <= 1'b0;
      over_r  <= 1'b0;
      idx_r   <= '0;
    end else if (cmd.scan_step) begin
      if (take) begin
        found_r <= 1'b1;
      end
      over_r <= last;
      idx_r  <= idx_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan_step && take) begin
      pick_r <= idx_r;
      best_r <= cap_cur;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < fhta_pkg::NUM_PROCS; i++) begin
        cap_r[i] <= fhta_pkg::CAP_ONE;
      end
    end else if (cmd.commit && found_r) begin
      cap_r[pick_r] <= new_cap;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.commit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      placed_r <= found_r;
      cpu_r    <= found_r ? pick_r : '0;
      left_r   <= found_r ? new_cap : '0;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_placed        = placed_r;
  assign out_proc_id       = cpu_r;
  assign out_capacity_left = left_r;

endmodule

// File: hw/rtl/fit_heuristic_task_allocator_unit.sv
// Fit-heuristic task allocator: each input beat carries one task (execution
// time and period); the block forms its Q1.16 utilisation floor(C*65536/T),
// places it on processor 0..cpus_in_use-1 by best, worst or first fit
// (fit_mode 0/1/2, mode 3 acts as first fit, ties go to the lowest index)
// and returns one result beat with placed, proc_id and capacity_left.
// A zero period or a utilisation above the free capacity of every processor
// gives placed 0 with zeroed fields and leaves all capacities alone. Capacities
// start at 1.0 after reset. One task is handled at a time: once the input
// beat is taken, the task passes through the bit-serial restoring divider,
// then a scan over the processors one by one (cpus_in_use saturated at 16,
// or up to and including the first hit under first fit), a step that ends
// the scan and a commit step, after which the result beat is presented. The
// next task can be taken in the cycle after the commit. A finished result
// sits in an output register, so the result beat may be stalled while the
// next task is being worked on; that task then waits at its commit. Write the
// configuration registers only while the block is idle.
module fit_heuristic_task_allocator_unit (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [fhta_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [fhta_pkg::CFG_DATA_W-1:0]   cfg_data,
  fhta_in_if.sink                           in_ch,
  fhta_out_if.source                        out_ch
);

  fhta_pkg::cmd_t cmd;
  fhta_pkg::sts_t sts;

  fhta_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  fhta_dp u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .exec_time         (in_ch.exec_time),
    .period            (in_ch.period),
    .out_ready         (out_ch.ready),
    .out_valid         (out_ch.valid),
    .out_placed        (out_ch.placed),
    .out_proc_id       (out_ch.proc_id),
    .out_capacity_left (out_ch.capacity_left),
    .cmd               (cmd),
    .sts               (sts)
  );

endmodule

// File: hw/rtl/fhta_checker.sv
module fhta_checker (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  input  logic                          in_ready,
  input  logic                          out_valid,
  input  logic                          out_ready,
  input  logic                          out_placed,
  input  logic [fhta_pkg::CPU_W-1:0]    out_proc_id,
  input  logic [fhta_pkg::CAP_W-1:0]    out_capacity_left
);

  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_placed |-> out_proc_id == '0 && out_capacity_left == '0)
    else $error("failed placement carries non-zero fields");

  a_cap_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_placed |-> out_capacity_left <= fhta_pkg::CAP_ONE)
    else $error("capacity above one");

  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken while a task is in progress");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_placed)
      && $stable(out_proc_id) && $stable(out_capacity_left))
    else $error("stalled result beat changed");

  a_rst_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result beat right after reset");

endmodule

bind fit_heuristic_task_allocator_unit fhta_checker u_fhta_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_valid          (in_ch.valid),
  .in_ready          (in_ch.ready),
  .out_valid         (out_ch.valid),
  .out_ready         (out_ch.ready),
  .out_placed        (out_ch.placed),
  .out_proc_id       (out_ch.proc_id),
  .out_capacity_left (out_ch.capacity_left)
);

// File: test/fit_heuristic_task_allocator_unit_tb.sv
module fit_heuristic_task_allocator_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import fhta_pkg::*;

  localparam int RANDOM_JOBS = 1500;
  localparam int LONG_HOLD   = 600;
  localparam int TAIL_CYCLES = 80;
  localparam int CYCLE_LIMIT = 1500000;

  typedef struct packed {
    logic [DATA_W-1:0] exec_time;
    logic [DATA_W-1:0] period;
  } job_t;

  typedef struct packed {
    logic             placed;
    logic [CPU_W-1:0] proc_id;
    logic [CAP_W-1:0] capacity_left;
  } placement_t;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  fhta_in_if  in_ch ();
  fhta_out_if out_ch ();

  fit_heuristic_task_allocator_unit u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  logic [CAP_W-1:0]  cpu_room [NUM_PROCS];
  logic [MODE_W-1:0] alloc_mode;
  logic [CNT_W-1:0]  alloc_cpus;

  job_t       pending_jobs [$];
  placement_t expected_placements [$];

  int  mismatches;
  int  cycles;
  int  jobs_offered;
  int  jobs_accepted;
  int  jobs_placed;
  int  jobs_refused;
  int  phases_run;
  bit  offering;
  int  burst_left;
  int  gap_left;
  job_t drv_job;
  int  hold_asks;
  int  hold_seen;
  int  hold_left;
  int  pat_age;
  logic [15:0] ready_pat;

  initial clk = 1'b0;
  always #4 clk = ~clk;

  function automatic placement_t place_job(logic [DATA_W-1:0] c, logic [DATA_W-1:0] t);
    placement_t       r;
    logic [DVD_W-1:0] util;
    int               n;
    bit               found;
    bit               stop;
    int               pick;
    r = '0;
    if (t == '0) return r;
    util  = {c, {FRAC_BITS{1'b0}}} / DVD_W'(t);
    n     = (alloc_cpus > NUM_PROCS) ? NUM_PROCS : int'(alloc_cpus);
    found = 1'b0;
    stop  = 1'b0;
    pick  = 0;
    for (int i = 0; i < n; i++) begin
      if (!stop && DVD_W'(cpu_room[i]) >= util) begin
        if (!found) begin
          found = 1'b1;
          pick  = i;
          stop  = (alloc_mode != MODE_BEST) && (alloc_mode != MODE_WORST);
        end else if (alloc_mode == MODE_BEST) begin
          if (cpu_room[i] < cpu_room[pick]) pick = i;
        end else if (alloc_mode == MODE_WORST) begin
          if (cpu_room[i] > cpu_room[pick]) pick = i;
        end
      end
    end
    if (!found) return r;
    cpu_room[pick]  = cpu_room[pick] - util[CAP_W-1:0];
    r.placed        = 1'b1;
    r.proc_id       = pick[CPU_W-1:0];
    r.capacity_left = cpu_room[pick];
    return r;
  endfunction

  function automatic job_t make_job();
    job_t        j;
    int          r;
    int          k;
    int          sel;
    logic [CAP_W-1:0] room;
    r = $urandom_range(0, 99);
    if (r < 65) begin
      j.period    = $urandom_range(32'h0001_0000, 32'hFFFF_FFFF);
      j.exec_time = (j.period >> $urandom_range(6, 16)) + $urandom_range(0, 3);
    end else if (r < 75) begin
      j.exec_time = '0;
      j.period    = $urandom;
    end else if (r < 80) begin
      j.exec_time = $urandom;
      j.period    = '0;
    end else if (r < 85) begin
      j.period    = $urandom_range(1, 65535);
      j.exec_time = j.period + $urandom_range(1, j.period);
    end else if (r < 89) begin
      k    = $urandom_range(0, NUM_PROCS - 1);
      room = cpu_room[k];
      sel  = $urandom_range(0, 2);
      j.period    = DATA_W'(CAP_ONE);
      j.exec_time = DATA_W'(room);
      if (sel == 0 && room != '0) j.exec_time = DATA_W'(room) - 1;
      if (sel == 2) j.exec_time = DATA_W'(room) + 1;
    end else if (r < 91) begin
      j.exec_time = $urandom;
      j.period    = $urandom;
    end else begin
      j.period    = $urandom_range(1, 4096);
      j.exec_time = $urandom_range(0, j.period >> 6);
    end
    return j;
  endfunction

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("[%0t] mismatch: %s got %0d want %0d", $time, what, got, want);
    mismatches++;
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(negedge clk);
    cfg_we    <= 1'b0;
    if (idx == CFG_FIT_MODE) alloc_mode = data[MODE_W-1:0];
    else alloc_cpus = data;
  endtask

  task automatic set_policy(input logic [MODE_W-1:0] mode, input logic [CNT_W-1:0] cpus);
    logic [CFG_DATA_W-1:0] mode_word;
    mode_word = CFG_DATA_W'($urandom) & ~CFG_DATA_W'(2'b11);
    mode_word = mode_word | CFG_DATA_W'(mode);
    if ($urandom_range(0, 1) == 0) begin
      write_reg(CFG_FIT_MODE, mode_word);
      write_reg(CFG_CPUS_IN_USE, cpus);
    end else begin
      write_reg(CFG_CPUS_IN_USE, cpus);
      write_reg(CFG_FIT_MODE, mode_word);
    end
    phases_run++;
  endtask

  task automatic queue_job(input logic [DATA_W-1:0] c, input logic [DATA_W-1:0] t);
    job_t j;
    j.exec_time = c;
    j.period    = t;
    pending_jobs.push_back(j);
  endtask

  task automatic wait_drained();
    while (pending_jobs.size() != 0 || offering || expected_placements.size() != 0)
      @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // sender: bursts of beats with random gaps
  always @(negedge clk) begin
    if (rst_n) begin
      if (offering && jobs_accepted == jobs_offered) offering = 1'b0;
      if (!offering) begin
        if (gap_left > 0) begin
          gap_left--;
          in_ch.valid <= 1'b0;
        end else if (pending_jobs.size() == 0) begin
          in_ch.valid <= 1'b0;
        end else begin
          drv_job = pending_jobs.pop_front();
          in_ch.exec_time <= drv_job.exec_time;
          in_ch.period    <= drv_job.period;
          in_ch.valid     <= 1'b1;
          offering = 1'b1;
          jobs_offered++;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(0, 31);
            gap_left   = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 60)
                                                     : $urandom_range(0, 4);
          end
        end
      end
    end
  end

  // receiver: rotating stall pattern, plus a long hold-off on request
  always @(negedge clk) begin
    if (rst_n) begin
      if (hold_seen != hold_asks) begin
        hold_seen = hold_asks;
        hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        if (pat_age == 0) begin
          pat_age = $urandom_range(50, 400);
          case ($urandom_range(0, 3))
            0:       ready_pat = 16'hFFFF;
            1:       ready_pat = 16'($urandom);
            2:       ready_pat = 16'($urandom) | 16'($urandom);
            default: ready_pat = 16'($urandom) & 16'($urandom);
          endcase
          ready_pat[0] = 1'b1;
        end else begin
          pat_age--;
          ready_pat = {ready_pat[14:0], ready_pat[15]};
        end
        out_ch.ready <= ready_pat[0];
      end
    end
  end

  always @(posedge clk) begin
    placement_t got;
    placement_t want;
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready) begin
        want = place_job(in_ch.exec_time, in_ch.period);
        expected_placements.push_back(want);
        jobs_accepted++;
        if (want.placed) jobs_placed++;
        else jobs_refused++;
      end
      if (out_ch.valid && out_ch.ready) begin
        got.placed        = out_ch.placed;
        got.proc_id       = out_ch.proc_id;
        got.capacity_left = out_ch.capacity_left;
        if (expected_placements.size() == 0) begin
          report_mismatch("result beat with none outstanding, proc_id", got.proc_id, 0);
        end else begin
          want = expected_placements.pop_front();
          if (got.placed !== want.placed)
            report_mismatch("placed", got.placed, want.placed);
          if (got.proc_id !== want.proc_id)
            report_mismatch("proc_id", got.proc_id, want.proc_id);
          if (got.capacity_left !== want.capacity_left)
            report_mismatch("capacity_left", got.capacity_left, want.capacity_left);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timed out after %0d cycles, %0d beats outstanding", cycles,
               expected_placements.size());
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin
    int random_sent;
    int len;
    int sel;
    int ph;
    logic [CNT_W-1:0] cpus;

    rst_n           = 1'b0;
    cfg_we          = 1'b0;
    cfg_index       = '0;
    cfg_data        = '0;
    in_ch.valid     = 1'b0;
    in_ch.exec_time = '0;
    in_ch.period    = '0;
    out_ch.ready    = 1'b0;
    mismatches      = 0;
    cycles          = 0;
    jobs_offered    = 0;
    jobs_accepted   = 0;
    jobs_placed     = 0;
    jobs_refused    = 0;
    phases_run      = 1;
    offering        = 1'b0;
    burst_left      = 0;
    gap_left        = 0;
    hold_asks       = 0;
    hold_seen       = 0;
    hold_left       = 0;
    pat_age         = 0;
    ready_pat       = 16'hFFFF;
    for (int i = 0; i < NUM_PROCS; i++) cpu_room[i] = CAP_ONE;
    alloc_mode      = MODE_BEST;
    alloc_cpus      = CPUS_RST;

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    queue_job(32'd0, 32'd0);
    queue_job(32'hFFFF_FFFF, 32'd0);
    queue_job(32'd0, 32'd1);
    queue_job(32'hFFFF_FFFF, 32'd1);
    queue_job(32'd65537, 32'd65536);
    queue_job(32'd1, 32'd4);
    queue_job(32'd1, 32'd8);
    queue_job(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    wait_drained();

    set_policy(MODE_WORST, CNT_W'(NUM_PROCS));
    queue_job(32'd1, 32'd2);
    queue_job(32'd3, 32'd7);
    queue_job(32'd0, 32'd5);
    queue_job(32'd1, 32'd3);
    wait_drained();

    set_policy(MODE_FIRST, CNT_W'(1));
    queue_job(32'd1, 32'd100);
    queue_job(32'd1, 32'd1);
    wait_drained();

    set_policy(MODE_SPARE, CNT_W'(0));
    queue_job(32'd0, 32'd1);
    queue_job(32'd1, 32'd1000);
    wait_drained();

    set_policy(MODE_SPARE, 5'd31);
    queue_job(32'd1, 32'd1);
    queue_job(32'h8000_0000, 32'hFFFF_FFFF);
    queue_job(32'h7FFF_FFFF, 32'h8000_0000);
    wait_drained();

    random_sent = 0;
    ph = 0;
    while (random_sent < RANDOM_JOBS) begin
      sel = $urandom_range(0, 9);
      case (sel)
        0:       cpus = '0;
        1:       cpus = CNT_W'(1);
        2:       cpus = CNT_W'($urandom_range(NUM_PROCS + 1, 31));
        3:       cpus = CNT_W'(NUM_PROCS);
        default: cpus = CNT_W'($urandom_range(1, NUM_PROCS));
      endcase
      set_policy(MODE_W'($urandom_range(0, 3)), cpus);
      len = (ph == 2) ? 40 : $urandom_range(8, 60);
      if (ph == 2) hold_asks++;
      for (int i = 0; i < len; i++) pending_jobs.push_back(make_job());
      random_sent += len;
      wait_drained();
      ph++;
    end

    repeat (TAIL_CYCLES) @(negedge clk);
    if (expected_placements.size() != 0)
      report_mismatch("results never delivered", 0, expected_placements.size());

    $display("%0d tasks through %0d fit/processor-count settings, %0d cycles",
             jobs_accepted, phases_run, cycles);
    $display("%0d placed, %0d refused, %0d mismatches", jobs_placed, jobs_refused,
             mismatches);
    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
